### design/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, microcode ROM and calendar helpers for the date unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int PC_W = 5;

	// command codes
	localparam logic [2:0] CMD_LOAD = 3'd0;
	localparam logic [2:0] CMD_NEXT = 3'd1;
	localparam logic [2:0] CMD_PREV = 3'd2;
	localparam logic [2:0] CMD_ADD  = 3'd3;
	localparam logic [2:0] CMD_SUB  = 3'd4;
	localparam logic [2:0] CMD_CMP  = 3'd5;
	localparam logic [2:0] CMD_DIFF = 3'd6;
	localparam logic [2:0] CMD_NONE = 3'd7;

	// microprogram entry points
	localparam logic [PC_W-1:0] A_LOAD = 5'd0;
	localparam logic [PC_W-1:0] A_NEXT = 5'd1;
	localparam logic [PC_W-1:0] A_PREV = 5'd4;
	localparam logic [PC_W-1:0] A_ADD  = 5'd7;
	localparam logic [PC_W-1:0] A_SUB  = 5'd11;
	localparam logic [PC_W-1:0] A_CMP  = 5'd15;
	localparam logic [PC_W-1:0] A_DIFF = 5'd17;
	localparam logic [PC_W-1:0] A_NONE = 5'd21;
	localparam logic [PC_W-1:0] A_FIN  = 5'd22;
	localparam logic [PC_W-1:0] A_DONE = 5'd23;

	// modular inverse of 25 mod 2^13, and the divisibility bound
	localparam logic [12:0] INV25   = 13'd7209;
	localparam logic [12:0] DIV25_LIM = 13'd327;

	localparam logic signed [12:0] BASE_YEAR = 13'sd1900;
	localparam logic signed [24:0] DAYS_4Y   = 25'sd1461;

	typedef enum logic [3:0] {
		U_NOP, U_LOAD, U_CHK_CUR, U_CHK_BOTH, U_NEXT, U_PREV, U_ADD_OFF, U_ADD_MON,
		U_SUB_OFF, U_SUB_MON, U_STORE, U_CMP, U_DN_OP, U_DN_CUR, U_DIFF, U_DONE
	} uop_t;

	typedef enum logic [2:0] {
		C_NEXT, C_JUMP, C_ERR, C_LOOP, C_WAIT
	} cond_t;

	typedef struct packed {
		uop_t            uop;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic start;
		uop_t uop;
	} ctrl_t;

	typedef struct packed {
		logic err;
		logic loop;
		logic out_free;
	} stat_t;

	typedef enum logic {
		S_IDLE, S_RUN
	} seq_state_t;

	// microcode ROM
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			5'd0:  w = '{U_LOAD,     C_JUMP, A_FIN};
			5'd1:  w = '{U_CHK_CUR,  C_ERR,  A_FIN};
			5'd2:  w = '{U_NEXT,     C_NEXT, A_FIN};
			5'd3:  w = '{U_STORE,    C_JUMP, A_FIN};
			5'd4:  w = '{U_CHK_CUR,  C_ERR,  A_FIN};
			5'd5:  w = '{U_PREV,     C_NEXT, A_FIN};
			5'd6:  w = '{U_STORE,    C_JUMP, A_FIN};
			5'd7:  w = '{U_CHK_CUR,  C_ERR,  A_FIN};
			5'd8:  w = '{U_ADD_OFF,  C_NEXT, A_FIN};
			5'd9:  w = '{U_ADD_MON,  C_LOOP, A_ADD + 5'd2};
			5'd10: w = '{U_STORE,    C_JUMP, A_FIN};
			5'd11: w = '{U_CHK_CUR,  C_ERR,  A_FIN};
			5'd12: w = '{U_SUB_OFF,  C_NEXT, A_FIN};
			5'd13: w = '{U_SUB_MON,  C_LOOP, A_SUB + 5'd2};
			5'd14: w = '{U_STORE,    C_JUMP, A_FIN};
			5'd15: w = '{U_CHK_BOTH, C_ERR,  A_FIN};
			5'd16: w = '{U_CMP,      C_JUMP, A_FIN};
			5'd17: w = '{U_CHK_BOTH, C_ERR,  A_FIN};
			5'd18: w = '{U_DN_OP,    C_NEXT, A_FIN};
			5'd19: w = '{U_DN_CUR,   C_NEXT, A_FIN};
			5'd20: w = '{U_DIFF,     C_JUMP, A_DONE};
			5'd21: w = '{U_CHK_CUR,  C_JUMP, A_FIN};
			5'd22: w = '{U_DN_CUR,   C_NEXT, A_FIN};
			default: w = '{U_DONE,   C_WAIT, A_LOAD};
		endcase
		return w;
	endfunction

	// dispatch table
	function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] cmd);
		logic [PC_W-1:0] a;
		unique case (cmd)
			CMD_LOAD: a = A_LOAD;
			CMD_NEXT: a = A_NEXT;
			CMD_PREV: a = A_PREV;
			CMD_ADD:  a = A_ADD;
			CMD_SUB:  a = A_SUB;
			CMD_CMP:  a = A_CMP;
			CMD_DIFF: a = A_DIFF;
			default:  a = A_NONE;
		endcase
		return a;
	endfunction

	// Gregorian leap test, signed year; divisibility by 25 via inverse multiply
	function automatic logic is_leap(input logic signed [13:0] y);
		logic [12:0] a;
		logic [12:0] p;
		logic        d25;
		a   = y[13] ? 13'(-y) : y[12:0];
		p   = 13'(a * INV25);
		d25 = (p <= DIV25_LIM);
		return (a[1:0] == 2'd0) && (!d25 || (a[3:0] == 4'd0));
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		unique case (m)
			4'd2:                      n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
			default:                   n = 5'd31;
		endcase
		return n;
	endfunction

	// days before the given month in a common year, March onward
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] s;
		unique case (m)
			4'd3:    s = 9'd59;
			4'd4:    s = 9'd90;
			4'd5:    s = 9'd120;
			4'd6:    s = 9'd151;
			4'd7:    s = 9'd181;
			4'd8:    s = 9'd212;
			4'd9:    s = 9'd243;
			4'd10:   s = 9'd273;
			4'd11:   s = 9'd304;
			4'd12:   s = 9'd334;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

### design/cau_dnum.sv
// ----------------------------------------------------------------------------
// cau_dnum
// Day of year and linear day number of one valid date.
// ----------------------------------------------------------------------------
module cau_dnum (
	input  logic [5:0]         day,
	input  logic [3:0]         month,
	input  logic [11:0]        year,
	output logic [8:0]         doy,
	output logic signed [20:0] dn
);
	import cau_pkg::*;

	logic               leap;
	logic signed [12:0] yrel;
	logic signed [24:0] span;
	logic signed [24:0] span_r;
	logic signed [24:0] quarter;
	logic signed [24:0] dn_w;

	// day within year
	always_comb begin
		leap = is_leap($signed({2'b00, year}));
		if (month < 4'd3) begin
			doy = (month < 4'd2) ? {3'b000, day} : ({3'b000, day} + 9'd31);
		end else begin
			doy = {3'b000, day} + month_start(month) + {8'd0, leap};
		end
	end

	// trunc((year - 1900) * 1461 / 4) + doy - 2, rounding toward zero
	always_comb begin
		yrel    = $signed({1'b0, year}) - BASE_YEAR;
		span    = 25'(yrel) * DAYS_4Y;
		span_r  = span[24] ? (span + 25'sd3) : span;
		quarter = span_r >>> 2;
		dn_w    = quarter + $signed({16'd0, doy}) - 25'sd2;
	end

	assign dn = dn_w[20:0];

endmodule

### design/cau_seq.sv
// ----------------------------------------------------------------------------
// cau_seq
// Microcode sequencer: step counter, ROM lookup, dispatch and jumps.
// ----------------------------------------------------------------------------
module cau_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [2:0]      command,
	input  cau_pkg::stat_t  stat,
	output cau_pkg::ctrl_t  ctrl
);
	import cau_pkg::*;

	seq_state_t      state_q, state_d;
	logic [PC_W-1:0] pc_q, pc_d;
	uword_t          word;
	logic            accept;

	assign word   = ucode(pc_q);
	assign accept = in_valid && (state_q == S_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_RUN;
			end
			S_RUN: begin
				if (word.cond == C_WAIT && stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// step counter
	always_comb begin
		pc_d = pc_q;
		if (accept) begin
			pc_d = entry_pc(command);
		end else if (state_q == S_RUN) begin
			unique case (word.cond)
				C_NEXT:  pc_d = pc_q + 5'd1;
				C_JUMP:  pc_d = word.target;
				C_ERR:   pc_d = stat.err ? word.target : (pc_q + 5'd1);
				C_LOOP:  pc_d = stat.loop ? word.target : (pc_q + 5'd1);
				default: pc_d = pc_q;
			endcase
		end
	end

	// outputs
	always_comb begin
		in_ready   = (state_q == S_IDLE);
		ctrl.start = accept;
		ctrl.uop   = (state_q == S_RUN) ? word.uop : U_NOP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= A_LOAD;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

endmodule

### design/cau_dp.sv
// ----------------------------------------------------------------------------
// cau_dp
// Datapath: stored date, working date, checks, result and output registers.
// ----------------------------------------------------------------------------
module cau_dp #(
	parameter int MIN_YEAR = 1800,
	parameter int MAX_YEAR = 2999
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cau_pkg::ctrl_t     ctrl,
	output cau_pkg::stat_t     stat,
	input  logic [5:0]         day,
	input  logic [3:0]         month,
	input  logic [11:0]        year,
	input  logic [15:0]        offset_days,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         out_day,
	output logic [3:0]         out_month,
	output logic [11:0]        out_year,
	output logic [2:0]         error_bits,
	output logic [8:0]         day_of_year,
	output logic signed [20:0] day_number,
	output logic               less,
	output logic signed [20:0] difference
);
	import cau_pkg::*;

	localparam logic [11:0] MIN_Y = 12'(MIN_YEAR);
	localparam logic [11:0] MAX_Y = 12'(MAX_YEAR);

	function automatic logic [2:0] check_date(input logic [5:0] d, input logic [3:0] m,
			input logic [11:0] y);
		logic [2:0] b;
		b[0] = (d < 6'd1) || (d > 6'd31);
		b[1] = (m < 4'd1) || (m > 4'd12);
		b[2] = (y < MIN_Y) || (y > MAX_Y);
		return b;
	endfunction

	// operand and stored date
	logic [5:0]         op_d_q;
	logic [3:0]         op_m_q;
	logic [11:0]        op_y_q;
	logic [15:0]        op_off_q;
	logic [5:0]         cur_day_q, cur_day_d;
	logic [3:0]         cur_month_q, cur_month_d;
	logic [11:0]        cur_year_q, cur_year_d;

	// working date
	logic signed [17:0] w_d_q, w_d_d;
	logic [3:0]         w_m_q, w_m_d;
	logic signed [13:0] w_y_q, w_y_d;
	logic               leap_q;

	// results
	logic [2:0]         err_q;
	logic               less_q;
	logic signed [20:0] diff_q;
	logic [8:0]         doy_q;
	logic signed [20:0] dn_q;
	logic signed [20:0] aux_q;

	// output register
	logic               out_valid_q;
	logic [5:0]         out_day_q;
	logic [3:0]         out_month_q;
	logic [11:0]        out_year_q;
	logic [2:0]         out_err_q;
	logic [8:0]         out_doy_q;
	logic signed [20:0] out_dn_q;
	logic               out_less_q;
	logic signed [20:0] out_diff_q;

	logic [2:0]         chk_cur, chk_op;
	logic [4:0]         md_cur, md_prev;
	logic [3:0]         m_prev, m_next;
	logic signed [13:0] y_prev, y_next;
	logic               add_more, sub_less, out_free, do_done;
	logic               dn_sel_op;
	logic [5:0]         dn_day;
	logic [3:0]         dn_month;
	logic [11:0]        dn_year;
	logic [8:0]         dn_doy;
	logic signed [20:0] dn_val;

	// checks and month stepping
	always_comb begin
		chk_cur  = check_date(cur_day_q, cur_month_q, cur_year_q);
		chk_op   = check_date(op_d_q, op_m_q, op_y_q);
		md_cur   = month_days(w_m_q, leap_q);
		m_next   = (w_m_q < 4'd12) ? (w_m_q + 4'd1) : 4'd1;
		y_next   = (w_m_q < 4'd12) ? w_y_q : (w_y_q + 14'sd1);
		m_prev   = (w_m_q > 4'd1) ? (w_m_q - 4'd1) : 4'd12;
		y_prev   = (w_m_q > 4'd1) ? w_y_q : (w_y_q - 14'sd1);
		// December has 31 days whatever the year, so leap_q of w_y suffices
		md_prev  = month_days(m_prev, leap_q);
		add_more = w_d_q > $signed({13'd0, md_cur});
		sub_less = w_d_q < 18'sd1;
		out_free = !out_valid_q || out_ready;
		do_done  = (ctrl.uop == U_DONE) && out_free;
	end

	always_comb begin
		stat.err      = (ctrl.uop == U_CHK_BOTH) ? ((chk_cur | chk_op) != 3'd0)
		                                         : (chk_cur != 3'd0);
		stat.loop     = (ctrl.uop == U_SUB_MON) ? sub_less : add_more;
		stat.out_free = out_free;
	end

	// shared day-number unit
	assign dn_sel_op = (ctrl.uop == U_DN_OP);
	assign dn_day    = dn_sel_op ? op_d_q : cur_day_q;
	assign dn_month  = dn_sel_op ? op_m_q : cur_month_q;
	assign dn_year   = dn_sel_op ? op_y_q : cur_year_q;

	cau_dnum u_dnum (
		.day   (dn_day),
		.month (dn_month),
		.year  (dn_year),
		.doy   (dn_doy),
		.dn    (dn_val)
	);

	// working and stored date updates
	always_comb begin
		w_d_d       = w_d_q;
		w_m_d       = w_m_q;
		w_y_d       = w_y_q;
		cur_day_d   = cur_day_q;
		cur_month_d = cur_month_q;
		cur_year_d  = cur_year_q;
		unique case (ctrl.uop)
			U_LOAD: begin
				cur_day_d   = op_d_q;
				cur_month_d = op_m_q;
				cur_year_d  = op_y_q;
			end
			U_CHK_CUR, U_CHK_BOTH: begin
				w_d_d = $signed({12'd0, cur_day_q});
				w_m_d = cur_month_q;
				w_y_d = $signed({2'b00, cur_year_q});
			end
			U_NEXT: begin
				if (w_d_q < $signed({13'd0, md_cur})) begin
					w_d_d = w_d_q + 18'sd1;
				end else begin
					w_d_d = 18'sd1;
					w_m_d = m_next;
					w_y_d = y_next;
				end
			end
			U_PREV: begin
				if (w_d_q > 18'sd1) begin
					w_d_d = w_d_q - 18'sd1;
				end else begin
					w_m_d = m_prev;
					w_y_d = y_prev;
					w_d_d = $signed({13'd0, md_prev});
				end
			end
			U_ADD_OFF: w_d_d = w_d_q + $signed({2'b00, op_off_q});
			U_SUB_OFF: w_d_d = w_d_q - $signed({2'b00, op_off_q});
			U_ADD_MON: begin
				if (add_more) begin
					w_d_d = w_d_q - $signed({13'd0, md_cur});
					w_m_d = m_next;
					w_y_d = y_next;
				end
			end
			U_SUB_MON: begin
				if (sub_less) begin
					w_d_d = w_d_q + $signed({13'd0, md_prev});
					w_m_d = m_prev;
					w_y_d = y_prev;
				end
			end
			U_STORE: begin
				cur_day_d   = w_d_q[5:0];
				cur_month_d = w_m_q;
				cur_year_d  = w_y_q[11:0];
			end
			default: ;
		endcase
	end

	// stored date
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_day_q   <= 6'd1;
			cur_month_q <= 4'd1;
			cur_year_q  <= 12'd1900;
		end else begin
			cur_day_q   <= cur_day_d;
			cur_month_q <= cur_month_d;
			cur_year_q  <= cur_year_d;
		end
	end

	// operand capture, working date and per-request results
	always_ff @(posedge clk) begin
		w_d_q  <= w_d_d;
		w_m_q  <= w_m_d;
		w_y_q  <= w_y_d;
		leap_q <= is_leap(w_y_d);
		if (ctrl.start) begin
			op_d_q   <= day;
			op_m_q   <= month;
			op_y_q   <= year;
			op_off_q <= offset_days;
			err_q    <= 3'd0;
			less_q   <= 1'b0;
			diff_q   <= '0;
		end
		unique case (ctrl.uop)
			U_LOAD:     err_q  <= chk_op;
			U_CHK_CUR:  err_q  <= chk_cur;
			U_CHK_BOTH: err_q  <= chk_cur | chk_op;
			U_CMP:      less_q <= {cur_year_q, cur_month_q, cur_day_q}
			                    < {op_y_q, op_m_q, op_d_q};
			U_DN_OP:    aux_q  <= dn_val;
			U_DN_CUR: begin
				doy_q <= (chk_cur == 3'd0) ? dn_doy : 9'd0;
				dn_q  <= (chk_cur == 3'd0) ? dn_val : 21'sd0;
			end
			U_DIFF:     diff_q <= dn_q - aux_q;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_done) begin
			out_day_q   <= cur_day_q;
			out_month_q <= cur_month_q;
			out_year_q  <= cur_year_q;
			out_err_q   <= err_q;
			out_doy_q   <= doy_q;
			out_dn_q    <= dn_q;
			out_less_q  <= less_q;
			out_diff_q  <= diff_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_day     = out_day_q;
	assign out_month   = out_month_q;
	assign out_year    = out_year_q;
	assign error_bits  = out_err_q;
	assign day_of_year = out_doy_q;
	assign day_number  = out_dn_q;
	assign less        = out_less_q;
	assign difference  = out_diff_q;

endmodule

### design/calendar_date_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_arithmetic_unit
// Stored Gregorian date with load, step, add, subtract, compare and difference.
// ----------------------------------------------------------------------------
// One request at a time: in_ready is high only while the sequencer is idle, and
// a result can wait in the output register while the next request is taken.
// in_ready comes back high in the same cycle as the result, so the next request
// can be taken in that cycle. The add and subtract loops walk one month per cycle
// through the microcoded sequencer.
module calendar_date_arithmetic_unit #(
	parameter int MIN_YEAR = 1800,
	parameter int MAX_YEAR = 2999
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         command,
	input  logic [5:0]         day,
	input  logic [3:0]         month,
	input  logic [11:0]        year,
	input  logic [15:0]        offset_days,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [5:0]         out_day,
	output logic [3:0]         out_month,
	output logic [11:0]        out_year,
	output logic [2:0]         error_bits,
	output logic [8:0]         day_of_year,
	output logic signed [20:0] day_number,
	output logic               less,
	output logic signed [20:0] difference
);
	import cau_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	// sequencer
	cau_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	// datapath
	cau_dp #(
		.MIN_YEAR (MIN_YEAR),
		.MAX_YEAR (MAX_YEAR)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.day         (day),
		.month       (month),
		.year        (year),
		.offset_days (offset_days),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_day     (out_day),
		.out_month   (out_month),
		.out_year    (out_year),
		.error_bits  (error_bits),
		.day_of_year (day_of_year),
		.day_number  (day_number),
		.less        (less),
		.difference  (difference)
	);

endmodule

### design/cau_chk.sv
// ----------------------------------------------------------------------------
// cau_chk
// Port-level checks for the date unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [5:0]         out_day,
	input logic [3:0]         out_month,
	input logic [11:0]        out_year,
	input logic [2:0]         error_bits,
	input logic [8:0]         day_of_year,
	input logic signed [20:0] day_number,
	input logic               less,
	input logic signed [20:0] difference
);

	// one request in flight: ready drops right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after accept");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_day)
			&& $stable(out_month) && $stable(out_year) && $stable(error_bits)
			&& $stable(difference)))
		else $error("stalled result changed");

	// a failed check leaves compare and difference clear
	a_err_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_bits != 3'd0) |-> (!less && difference == 21'sd0))
		else $error("compare or difference set on error");

	// an invalid stored date reports day number zero
	a_dn_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && day_of_year == 9'd0) |-> (day_number == 21'sd0))
		else $error("day number set for invalid date");

endmodule

bind calendar_date_arithmetic_unit cau_chk u_cau_chk (.*);
